// ===== hdl/y2r_pkg.sv =====
// Shared constants, coefficients and types of the YUYV to RGB pixel converter.
package y2r_pkg;

	localparam int COEF_FRACTION_BITS = 12;
	localparam int COEF_W = COEF_FRACTION_BITS + 2;
	localparam int PROD_W = COEF_W + 10;
	localparam int SUM_W = COEF_W + 11;
	localparam longint DEC_SCALE = 100000;

	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 48;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [0:0] REG_CHANNEL_ORDER = 1'b0;

	localparam logic [8:0] LUMA_OFFSET = 9'd16;
	localparam logic [8:0] CHROMA_OFFSET = 9'd128;

	// Decimal constant in units of 1e-5, scaled to Q format, rounded half up.
	function automatic longint qcoef(input longint num);
		return ((num <<< COEF_FRACTION_BITS) + DEC_SCALE / 2) / DEC_SCALE;
	endfunction

	localparam logic [COEF_W-1:0] COEF_RV = COEF_W'(qcoef(128033));
	localparam logic [COEF_W-1:0] COEF_GU = COEF_W'(qcoef(21482));
	localparam logic [COEF_W-1:0] COEF_GV = COEF_W'(qcoef(38059));
	localparam logic [COEF_W-1:0] COEF_BU = COEF_W'(qcoef(221798));

	typedef struct packed {
		logic ld_s3;
		logic ld_s4;
		logic bgr;
	} y2r_ctl_t;

endpackage

// ===== hdl/yuyv_to_rgb_pixel_converter.sv =====
// Top level of the YUYV macropixel to RGB888 pixel-pair converter.
//
// Input stream: one YUYV macropixel per item on s_tdata (Y0, U, Y1, V from
// the low byte up). Output stream: one item per input item, holding two
// 24-bit pixels that share the chroma, each channel clamped to 0..255. The
// APB register channel_order (address 0, bit 0) selects RGB (0) or BGR (1)
// byte order; the user writes it only while no item is in flight; not enforced.
//
// Four register stages: input register, chroma multipliers, channel sums,
// then shift, clamp and byte order. An accepted item passes them in that
// order and m_tvalid rises once it is in the output register. Throughput is
// one item per cycle while the receiver does not stall; the four multipliers
// are shared by both pixels of an item and are the only multiplier stage.
//
// Reset empties the pipeline and sets RGB order. When the receiver stalls,
// the output register holds its item and earlier stages keep filling any
// empty slots, so up to four items are held before s_tready falls.
module yuyv_to_rgb_pixel_converter (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// luma_first, chroma_u, luma_second, chroma_v
	input  logic [y2r_pkg::IN_DATA_W-1:0]      s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// first_chan0, first_chan1, first_chan2, second_chan0, second_chan1, second_chan2
	output logic [y2r_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [y2r_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [y2r_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [y2r_pkg::APB_DATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int PW = y2r_pkg::PROD_W;

	logic channel_order_q;
	logic reg_sel;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [8:0] luma_a_s1, luma_b_s1, chroma_u_s1, chroma_v_s1;
	logic signed [8:0] luma_a_s2, luma_b_s2;
	logic signed [PW-1:0] prod_rv_s2, prod_gu_s2, prod_gv_s2, prod_bu_s2;

	y2r_pkg::y2r_ctl_t ctl;
	logic [7:0] a_chan0, a_chan1, a_chan2, b_chan0, b_chan1, b_chan2;

	// Configuration port.
	assign pready = 1'b1;
	assign reg_sel = (paddr[y2r_pkg::APB_ADDR_W-1:2] == y2r_pkg::REG_CHANNEL_ORDER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_order_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			channel_order_q <= pwdata[0];
		end
	end

	assign prdata = reg_sel ? {{(y2r_pkg::APB_DATA_W-1){1'b0}}, channel_order_q} : '0;

	// A stage loads when it is empty or its content moves on.
	assign rdy4 = !v_s4 || m_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			luma_a_s1 <= $signed({1'b0, s_tdata[7:0]} - y2r_pkg::LUMA_OFFSET);
			chroma_u_s1 <= $signed({1'b0, s_tdata[15:8]} - y2r_pkg::CHROMA_OFFSET);
			luma_b_s1 <= $signed({1'b0, s_tdata[23:16]} - y2r_pkg::LUMA_OFFSET);
			chroma_v_s1 <= $signed({1'b0, s_tdata[31:24]} - y2r_pkg::CHROMA_OFFSET);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			luma_a_s2 <= luma_a_s1;
			luma_b_s2 <= luma_b_s1;
			prod_rv_s2 <= PW'($signed({1'b0, y2r_pkg::COEF_RV})) * PW'(chroma_v_s1);
			prod_gu_s2 <= PW'($signed({1'b0, y2r_pkg::COEF_GU})) * PW'(chroma_u_s1);
			prod_gv_s2 <= PW'($signed({1'b0, y2r_pkg::COEF_GV})) * PW'(chroma_v_s1);
			prod_bu_s2 <= PW'($signed({1'b0, y2r_pkg::COEF_BU})) * PW'(chroma_u_s1);
		end
	end

	always_comb begin
		ctl.ld_s3 = rdy3 && v_s2;
		ctl.ld_s4 = rdy4 && v_s3;
		ctl.bgr = channel_order_q;
	end

	y2r_pixel u_pix_first (
		.clk        (clk),
		.ctl        (ctl),
		.luma_s2    (luma_a_s2),
		.prod_rv_s2 (prod_rv_s2),
		.prod_gu_s2 (prod_gu_s2),
		.prod_gv_s2 (prod_gv_s2),
		.prod_bu_s2 (prod_bu_s2),
		.chan0_s4   (a_chan0),
		.chan1_s4   (a_chan1),
		.chan2_s4   (a_chan2)
	);

	y2r_pixel u_pix_second (
		.clk        (clk),
		.ctl        (ctl),
		.luma_s2    (luma_b_s2),
		.prod_rv_s2 (prod_rv_s2),
		.prod_gu_s2 (prod_gu_s2),
		.prod_gv_s2 (prod_gv_s2),
		.prod_bu_s2 (prod_bu_s2),
		.chan0_s4   (b_chan0),
		.chan1_s4   (b_chan1),
		.chan2_s4   (b_chan2)
	);

	assign m_tvalid = v_s4;
	assign m_tdata = {b_chan2, b_chan1, b_chan0, a_chan2, a_chan1, a_chan0};

endmodule

// ===== hdl/y2r_pixel.sv =====
// Channel sums, floor shift, clamp and channel ordering for one pixel.
module y2r_pixel (
	input  logic                               clk,
	input  y2r_pkg::y2r_ctl_t                  ctl,
	input  logic signed [8:0]                  luma_s2,
	input  logic signed [y2r_pkg::PROD_W-1:0]  prod_rv_s2,
	input  logic signed [y2r_pkg::PROD_W-1:0]  prod_gu_s2,
	input  logic signed [y2r_pkg::PROD_W-1:0]  prod_gv_s2,
	input  logic signed [y2r_pkg::PROD_W-1:0]  prod_bu_s2,
	output logic [7:0]                         chan0_s4,
	output logic [7:0]                         chan1_s4,
	output logic [7:0]                         chan2_s4
);

	localparam int F = y2r_pkg::COEF_FRACTION_BITS;
	localparam int SW = y2r_pkg::SUM_W;

	logic signed [SW-1:0] luma_sc;
	logic signed [SW-1:0] sum_r_s3;
	logic signed [SW-1:0] sum_g_s3;
	logic signed [SW-1:0] sum_b_s3;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	function automatic logic [7:0] clamp_byte(input logic signed [SW-1:0] sum);
		logic [SW-F-1:0] q;
		q = sum[SW-1:F];
		if (q[SW-F-1]) begin
			return 8'd0;
		end else if (|q[SW-F-2:8]) begin
			return 8'd255;
		end
		return q[7:0];
	endfunction

	assign luma_sc = SW'(luma_s2) <<< F;

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			sum_r_s3 <= luma_sc + SW'(prod_rv_s2);
			sum_g_s3 <= luma_sc - SW'(prod_gu_s2) - SW'(prod_gv_s2);
			sum_b_s3 <= luma_sc + SW'(prod_bu_s2);
		end
	end

	// Dropping the fraction bits inside clamp_byte is a floor toward minus infinity.
	always_comb begin
		red = clamp_byte(sum_r_s3);
		green = clamp_byte(sum_g_s3);
		blue = clamp_byte(sum_b_s3);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			chan0_s4 <= ctl.bgr ? blue : red;
			chan1_s4 <= green;
			chan2_s4 <= ctl.bgr ? red : blue;
		end
	end

endmodule

// ===== hdl/y2r_checker.sv =====
// Port-level checks of the converter, bound to the top level.
module y2r_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [y2r_pkg::OUT_DATA_W-1:0]    m_tdata,
	input logic                              pready
);

	// With the output register empty, every stage is free to load.
	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready while output is empty");

	// Nothing is in flight right after reset, so no item can be shown yet.
	a_empty_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !m_tvalid)
		else $error("output item right after reset");

	// An item must pass every register stage to reach the output, so it is not shown yet either.
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) ##1 1'b1 |-> !m_tvalid)
		else $error("output item faster than pipeline depth");

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output item changed");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind yuyv_to_rgb_pixel_converter y2r_checker u_y2r_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

// ===== sim/testbench.sv =====
// Self-checking testbench of the YUYV macropixel to RGB888 pixel-pair converter.
`timescale 1ns / 1ps

module testbench;

	localparam int PIPE_LATENCY = 4;
	localparam int STALL_LIMIT = 1000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int PRINT_CAP = 60;

	// Q12 coefficients, rounded half up from the decimal constants.
	localparam int FRAC_BITS = 12;
	localparam int K_RV = (128033 * (1 << FRAC_BITS) + 50000) / 100000;
	localparam int K_GU = (21482 * (1 << FRAC_BITS) + 50000) / 100000;
	localparam int K_GV = (38059 * (1 << FRAC_BITS) + 50000) / 100000;
	localparam int K_BU = (221798 * (1 << FRAC_BITS) + 50000) / 100000;
	localparam int LUMA_BLACK = 16;
	localparam int CHROMA_ZERO = 128;

	localparam logic [y2r_pkg::APB_ADDR_W-1:0] ADDR_CHANNEL_ORDER =
		y2r_pkg::APB_ADDR_W'(4 * int'(y2r_pkg::REG_CHANNEL_ORDER));
	localparam logic [y2r_pkg::APB_ADDR_W-1:0] ADDR_UNMAPPED = y2r_pkg::APB_ADDR_W'(4);

	typedef enum bit {
		ORDER_RGB = 1'b0,
		ORDER_BGR = 1'b1
	} chan_order_e;

	// Field order from the high bits down, so luma_first lands in the low byte.
	typedef struct packed {
		logic [7:0] chroma_v;
		logic [7:0] luma_second;
		logic [7:0] chroma_u;
		logic [7:0] luma_first;
	} macropixel_t;

	typedef struct packed {
		logic [7:0] chan2;
		logic [7:0] chan1;
		logic [7:0] chan0;
	} rgb_px_t;

	typedef struct packed {
		rgb_px_t second_px;
		rgb_px_t first_px;
	} pixel_pair_t;

	typedef struct packed {
		logic [31:0] data;
		logic        typed;
		logic [47:0] pair;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 20;

	// Rows with typed set carry the RGB-order result worked out by hand.
	stim_row_t directed_rows [DIRECTED_ROWS] = '{
		'{32'h80_10_80_10, 1'b1, 48'h0000_0000_0000},
		'{32'h80_FF_80_FF, 1'b1, 48'hEFEF_EFEF_EFEF},
		'{32'h80_00_80_00, 1'b1, 48'h0000_0000_0000},
		'{32'h00_FF_00_00, 1'b1, 48'h00FF_4B00_3C00},
		'{32'hFF_FF_FF_FF, 1'b0, 48'h0},
		'{32'hFF_00_FF_00, 1'b0, 48'h0},
		'{32'h00_00_00_00, 1'b0, 48'h0},
		'{32'hFF_00_00_FF, 1'b0, 48'h0},
		'{32'h00_FF_FF_00, 1'b0, 48'h0},
		'{32'h80_80_80_80, 1'b0, 48'h0},
		'{32'h10_EB_F0_10, 1'b0, 48'h0},
		'{32'hF0_10_10_EB, 1'b0, 48'h0},
		'{32'hF0_91_5A_51, 1'b0, 48'h0},
		'{32'h22_29_36_91, 1'b0, 48'h0},
		'{32'h6E_51_F0_29, 1'b0, 48'h0},
		'{32'h81_FE_7F_01, 1'b0, 48'h0},
		'{32'h7F_01_81_FE, 1'b0, 48'h0},
		'{32'hAA_55_55_AA, 1'b0, 48'h0},
		'{32'h55_AA_AA_55, 1'b0, 48'h0},
		'{32'h0F_F0_0F_F0, 1'b0, 48'h0}
	};

	string field_names [6] = '{"first_chan0", "first_chan1", "first_chan2",
		"second_chan0", "second_chan1", "second_chan2"};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// luma_first, chroma_u, luma_second, chroma_v
	logic [y2r_pkg::IN_DATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// first_chan0, first_chan1, first_chan2, second_chan0, second_chan1, second_chan2
	logic [y2r_pkg::OUT_DATA_W-1:0] m_tdata;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [y2r_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [y2r_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [y2r_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	chan_order_e order_shadow = ORDER_RGB;
	pixel_pair_t pending_pairs [$];
	int mismatch_count = 0;
	int printed_lines = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;
	pixel_pair_t got_pair;
	pixel_pair_t want_pair;

	yuyv_to_rgb_pixel_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatch_count++;
		if (printed_lines < PRINT_CAP) begin
			printed_lines++;
			$display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
		end
	endtask

	// Floor division by 2^FRAC_BITS, then saturation to a byte.
	function automatic logic [7:0] floor_clamp(input int acc);
		int q;
		q = acc >>> FRAC_BITS;
		if (q < 0)
			return 8'd0;
		if (q > 255)
			return 8'd255;
		return q[7:0];
	endfunction

	function automatic rgb_px_t convert_pixel(input logic [7:0] luma, input int u, input int v,
			input chan_order_e order);
		int ys;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		rgb_px_t px;
		ys = (int'(luma) - LUMA_BLACK) * (1 << FRAC_BITS);
		r = floor_clamp(ys + K_RV * v);
		g = floor_clamp(ys - K_GU * u - K_GV * v);
		b = floor_clamp(ys + K_BU * u);
		px.chan1 = g;
		if (order == ORDER_BGR) begin
			px.chan0 = b;
			px.chan2 = r;
		end else begin
			px.chan0 = r;
			px.chan2 = b;
		end
		return px;
	endfunction

	function automatic pixel_pair_t convert_macropixel(input macropixel_t mp,
			input chan_order_e order);
		int u;
		int v;
		pixel_pair_t pair;
		u = int'(mp.chroma_u) - CHROMA_ZERO;
		v = int'(mp.chroma_v) - CHROMA_ZERO;
		pair.first_px = convert_pixel(mp.luma_first, u, v, order);
		pair.second_px = convert_pixel(mp.luma_second, u, v, order);
		return pair;
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd128;
			4: return 8'd235;
			5: return 8'd240;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly uniform macropixels, a quarter built mostly from black, white and chroma corner bytes.
	function automatic logic [31:0] random_macropixel();
		if ($urandom_range(3) == 0)
			return {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
		return $urandom;
	endfunction

	task automatic apb_write(input logic [y2r_pkg::APB_ADDR_W-1:0] addr,
			input logic [y2r_pkg::APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_CHANNEL_ORDER)
			order_shadow = chan_order_e'(data[0]);
		@(posedge clk);
	endtask

	task automatic apb_check_order();
		logic [y2r_pkg::APB_DATA_W-1:0] value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_CHANNEL_ORDER;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (value !== y2r_pkg::APB_DATA_W'(order_shadow))
			report_mismatch("channel_order readback", 64'(value), 64'(order_shadow));
		@(posedge clk);
	endtask

	task automatic send_item(input logic [31:0] data, input logic typed,
			input logic [47:0] typed_pair);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		if (typed)
			pending_pairs.push_back(pixel_pair_t'(typed_pair));
		else
			pending_pairs.push_back(convert_macropixel(macropixel_t'(data), order_shadow));
	endtask

	task automatic wait_drained();
		while (pending_pairs.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	// hold_at starts a long receiver stall, pause_at lets the pipeline run dry first.
	task automatic send_random(input int count, input int hold_at, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_request = 1'b1;
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_pairs.size() != 0);
			end
			send_item(random_macropixel(), 1'b0, '0);
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_order(input logic [y2r_pkg::APB_DATA_W-1:0] value);
		wait_drained();
		apb_write(ADDR_CHANNEL_ORDER, value);
		apb_check_order();
	endtask

	// Receiver: checks each accepted item, then decides tready for the next edge.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_pair = pixel_pair_t'(m_tdata);
			if (pending_pairs.size() == 0) begin
				report_mismatch("unexpected item", 64'(m_tdata), '0);
			end else begin
				want_pair = pending_pairs.pop_front();
				for (int i = 0; i < 6; i++)
					if (got_pair[i*8 +: 8] !== want_pair[i*8 +: 8])
						report_mismatch(field_names[i], 64'(got_pair[i*8 +: 8]),
							64'(want_pair[i*8 +: 8]));
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_OFF_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[yuyv_to_rgb_pixel_converter] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_check_order();

		send_idle_pct = 9;
		recv_idle_pct = 72;
		for (int i = 0; i < DIRECTED_ROWS; i++)
			send_item(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].pair);
		s_tvalid <= 1'b0;
		@(posedge clk);
		set_order(32'(ORDER_BGR));
		send_random(200, -1, -1);
		// Only bit 0 of the register is kept.
		set_order({31'h7FFF_FFFF, ORDER_RGB});
		send_random(200, 120, -1);

		send_idle_pct = 72;
		recv_idle_pct = 9;
		wait_drained();
		apb_write(ADDR_UNMAPPED, 32'(ORDER_BGR));
		apb_check_order();
		set_order({31'h4000_0000, ORDER_BGR});
		send_random(200, -1, 100);
		set_order(32'(ORDER_RGB));
		send_random(200, -1, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_order(32'(ORDER_BGR));
		send_random(215, 50, 150);
		set_order(32'(ORDER_RGB));
		send_random(215, 100, -1);

		wait_drained();
		repeat (PIPE_LATENCY * 2) @(posedge clk);
		if (mismatch_count == 0)
			$display("[yuyv_to_rgb_pixel_converter] OK");
		else
			$display("[yuyv_to_rgb_pixel_converter] ERROR");
		$finish;
	end

endmodule
